@@ hdl/osm_pkg.sv @@
// ----------------------------------------------------------------------------
// osm_pkg
// Flag masks, operation and notification codes, and the update record for
// the ownership state machine.
// ----------------------------------------------------------------------------
package osm_pkg;

    localparam int FLAG_W = 14;
    localparam int CODE_W = 4;

    typedef logic [FLAG_W-1:0] flags_t;
    typedef logic [CODE_W-1:0] code_t;

    localparam flags_t FL_OWN     = 14'h0001;
    localparam flags_t FL_UNOWN   = 14'h0002;
    localparam flags_t FL_DIV     = 14'h0004;
    localparam flags_t FL_NDIV    = 14'h0008;
    localparam flags_t FL_ASK     = 14'h0010;
    localparam flags_t FL_NASK    = 14'h0020;
    localparam flags_t FL_ABLE    = 14'h0040;
    localparam flags_t FL_NABLE   = 14'h0080;
    localparam flags_t FL_PEND    = 14'h0100;
    localparam flags_t FL_NACQ    = 14'h0200;
    localparam flags_t FL_ACQ     = 14'h0400;
    localparam flags_t FL_TCANCEL = 14'h0800;
    localparam flags_t FL_WILL    = 14'h1000;
    localparam flags_t FL_NTRY    = 14'h2000;

    localparam flags_t SET_OWNED   = FL_OWN | FL_NDIV | FL_NASK;
    localparam flags_t SET_UNOWNED = FL_UNOWN | FL_ABLE | FL_NACQ | FL_NTRY;
    localparam flags_t FLAGS_RESET = FL_UNOWN | FL_NABLE;

    localparam code_t OP_NONE         = 4'd0;
    localparam code_t OP_CANCEL_NEG   = 4'd1;
    localparam code_t OP_CANCEL_ACQ   = 4'd2;
    localparam code_t OP_FORCED_ACQ   = 4'd3;
    localparam code_t OP_FORCED_DIV   = 4'd4;
    localparam code_t OP_NEG_DIV      = 4'd5;
    localparam code_t OP_ACQ          = 4'd6;
    localparam code_t OP_ACQ_IF_AVAIL = 4'd7;
    localparam code_t OP_REL_FAIL     = 4'd8;
    localparam code_t OP_REL_SUCC     = 4'd9;
    localparam code_t OP_PUBLISH      = 4'd10;
    localparam code_t OP_UNCOND_DIV   = 4'd11;
    localparam code_t OP_UNPUBLISH    = 4'd12;

    localparam code_t NT_NONE           = 4'd0;
    localparam code_t NT_CONFIRM_CANCEL = 4'd1;
    localparam code_t NT_ACQUIRED       = 4'd2;
    localparam code_t NT_DIVESTED       = 4'd3;
    localparam code_t NT_UNAVAILABLE    = 4'd4;
    localparam code_t NT_REQ_ASSUME     = 4'd5;
    localparam code_t NT_REQ_RELEASE    = 4'd6;
    localparam code_t NT_FORCED_ACQ     = 4'd7;
    localparam code_t NT_FORCED_DIV     = 4'd8;

    localparam logic MODE_OPERATION    = 1'b0;
    localparam logic MODE_NOTIFICATION = 1'b1;

    typedef struct packed {
        logic   accepted;
        flags_t flags;
        code_t  pending;
    } upd_t;

endpackage

@@ hdl/osm_next.sv @@
// ----------------------------------------------------------------------------
// osm_next
// Guard check and flag update for one operation or notification.
// ----------------------------------------------------------------------------
module osm_next
(
    input  logic             mode,
    input  osm_pkg::code_t   code,
    input  osm_pkg::flags_t  flags,
    input  osm_pkg::code_t   pending,
    output osm_pkg::upd_t    upd
);

    osm_pkg::flags_t f;
    logic            forced_unown;
    logic            forced_own;

    assign f = flags;

    assign forced_unown = (pending == osm_pkg::OP_FORCED_ACQ) &&
                          ((code == osm_pkg::OP_NEG_DIV) ||
                           (code == osm_pkg::OP_UNCOND_DIV) ||
                           (code == osm_pkg::OP_FORCED_DIV));
    assign forced_own   = (pending == osm_pkg::OP_FORCED_DIV) &&
                          ((code == osm_pkg::OP_ACQ) ||
                           (code == osm_pkg::OP_ACQ_IF_AVAIL) ||
                           (code == osm_pkg::OP_FORCED_ACQ));

    always_comb
    begin
        upd.accepted = 1'b0;
        upd.flags    = f;
        upd.pending  = pending;
        if (mode == osm_pkg::MODE_OPERATION)
        begin
            priority if (forced_unown)
            begin
                upd.accepted = 1'b1;
                upd.flags    = osm_pkg::SET_UNOWNED;
                upd.pending  = osm_pkg::OP_NONE;
            end
            else if (forced_own)
            begin
                upd.accepted = 1'b1;
                upd.flags    = osm_pkg::SET_OWNED;
                upd.pending  = osm_pkg::OP_NONE;
            end
            else
            begin
                unique case (code)
                    osm_pkg::OP_PUBLISH:
                    begin
                        if ((f & osm_pkg::FL_NABLE) != '0)
                        begin
                            upd.accepted = 1'b1;
                            upd.flags    = (f & ~osm_pkg::FL_NABLE) | osm_pkg::FL_ABLE |
                                           osm_pkg::FL_NACQ | osm_pkg::FL_NTRY;
                            upd.pending  = osm_pkg::OP_PUBLISH;
                        end
                    end
                    osm_pkg::OP_UNPUBLISH:
                    begin
                        if ((f & osm_pkg::FL_NABLE) == '0)
                        begin
                            upd.accepted = 1'b1;
                            upd.flags    = osm_pkg::FLAGS_RESET;
                            upd.pending  = osm_pkg::OP_UNPUBLISH;
                        end
                    end
                    osm_pkg::OP_CANCEL_NEG:
                    begin
                        if ((f & osm_pkg::FL_DIV) != '0)
                        begin
                            upd.accepted = 1'b1;
                            upd.flags    = (f & ~osm_pkg::FL_DIV) | osm_pkg::FL_NDIV;
                            upd.pending  = (pending == osm_pkg::OP_NEG_DIV) ?
                                           osm_pkg::OP_NONE : osm_pkg::OP_CANCEL_NEG;
                        end
                    end
                    osm_pkg::OP_CANCEL_ACQ:
                    begin
                        if ((f & osm_pkg::FL_ACQ) != '0)
                        begin
                            upd.accepted = 1'b1;
                            upd.flags    = (f & ~osm_pkg::FL_ACQ) | osm_pkg::FL_TCANCEL;
                            upd.pending  = osm_pkg::OP_CANCEL_ACQ;
                        end
                    end
                    osm_pkg::OP_NEG_DIV:
                    begin
                        if ((f & osm_pkg::FL_NDIV) != '0)
                        begin
                            upd.accepted = 1'b1;
                            upd.flags    = (f & ~osm_pkg::FL_NDIV) | osm_pkg::FL_DIV;
                            upd.pending  = (pending == osm_pkg::OP_CANCEL_NEG) ?
                                           osm_pkg::OP_NONE : osm_pkg::OP_NEG_DIV;
                        end
                    end
                    osm_pkg::OP_ACQ:
                    begin
                        if ((f & osm_pkg::FL_NACQ) != '0)
                        begin
                            upd.accepted = 1'b1;
                            upd.flags    = (f & ~(osm_pkg::FL_NACQ | osm_pkg::FL_WILL)) |
                                           osm_pkg::FL_ACQ | osm_pkg::FL_PEND |
                                           osm_pkg::FL_NTRY;
                            upd.pending  = osm_pkg::OP_ACQ;
                        end
                    end
                    osm_pkg::OP_ACQ_IF_AVAIL:
                    begin
                        if (((f & osm_pkg::FL_NTRY) != '0) && ((f & osm_pkg::FL_PEND) == '0))
                        begin
                            upd.accepted = 1'b1;
                            upd.flags    = (f & ~osm_pkg::FL_NTRY) | osm_pkg::FL_WILL;
                            upd.pending  = osm_pkg::OP_ACQ_IF_AVAIL;
                        end
                    end
                    osm_pkg::OP_REL_FAIL:
                    begin
                        if ((f & osm_pkg::FL_ASK) != '0)
                        begin
                            upd.accepted = 1'b1;
                            upd.flags    = (f & ~osm_pkg::FL_ASK) | osm_pkg::FL_NASK;
                            upd.pending  = osm_pkg::OP_REL_FAIL;
                        end
                    end
                    osm_pkg::OP_REL_SUCC:
                    begin
                        if ((f & osm_pkg::FL_ASK) != '0)
                        begin
                            upd.accepted = 1'b1;
                            upd.flags    = (f & ~(osm_pkg::FL_ASK | osm_pkg::FL_DIV |
                                                  osm_pkg::FL_NDIV | osm_pkg::FL_OWN)) |
                                           osm_pkg::SET_UNOWNED;
                            upd.pending  = osm_pkg::OP_REL_SUCC;
                        end
                    end
                    osm_pkg::OP_UNCOND_DIV:
                    begin
                        if ((f & osm_pkg::FL_OWN) != '0)
                        begin
                            upd.accepted = 1'b1;
                            upd.flags    = (f & ~(osm_pkg::FL_ASK | osm_pkg::FL_DIV |
                                                  osm_pkg::FL_NASK | osm_pkg::FL_NDIV |
                                                  osm_pkg::FL_OWN)) |
                                           osm_pkg::SET_UNOWNED;
                            upd.pending  = osm_pkg::OP_UNCOND_DIV;
                        end
                    end
                    osm_pkg::OP_FORCED_ACQ:
                    begin
                        if ((f & osm_pkg::FL_UNOWN) != '0)
                        begin
                            upd.accepted = 1'b1;
                            upd.flags    = osm_pkg::SET_OWNED;
                            upd.pending  = osm_pkg::OP_FORCED_ACQ;
                        end
                    end
                    osm_pkg::OP_FORCED_DIV:
                    begin
                        if ((f & osm_pkg::FL_OWN) != '0)
                        begin
                            upd.accepted = 1'b1;
                            upd.flags    = osm_pkg::SET_UNOWNED;
                            upd.pending  = osm_pkg::OP_FORCED_DIV;
                        end
                    end
                    default:
                    begin
                        upd.accepted = 1'b0;
                    end
                endcase
            end
        end
        else
        begin
            unique case (code)
                osm_pkg::NT_CONFIRM_CANCEL:
                begin
                    if ((f & osm_pkg::FL_TCANCEL) != '0)
                    begin
                        upd.accepted = 1'b1;
                        upd.flags    = (f & ~(osm_pkg::FL_PEND | osm_pkg::FL_TCANCEL)) |
                                       osm_pkg::FL_NACQ;
                    end
                end
                osm_pkg::NT_ACQUIRED:
                begin
                    if ((f & (osm_pkg::FL_PEND | osm_pkg::FL_WILL)) != '0)
                    begin
                        upd.accepted = 1'b1;
                        upd.flags    = (f & ~(osm_pkg::FL_ABLE | osm_pkg::FL_ACQ |
                                              osm_pkg::FL_PEND | osm_pkg::FL_NACQ |
                                              osm_pkg::FL_NTRY | osm_pkg::FL_TCANCEL |
                                              osm_pkg::FL_UNOWN | osm_pkg::FL_WILL)) |
                                       osm_pkg::SET_OWNED;
                    end
                end
                osm_pkg::NT_DIVESTED:
                begin
                    if ((f & osm_pkg::FL_DIV) != '0)
                    begin
                        upd.accepted = 1'b1;
                        upd.flags    = (f & ~(osm_pkg::FL_DIV | osm_pkg::FL_ASK |
                                              osm_pkg::FL_NASK | osm_pkg::FL_OWN)) |
                                       osm_pkg::SET_UNOWNED;
                    end
                end
                osm_pkg::NT_UNAVAILABLE:
                begin
                    if ((f & osm_pkg::FL_WILL) != '0)
                    begin
                        upd.accepted = 1'b1;
                        upd.flags    = (f & ~osm_pkg::FL_WILL) | osm_pkg::FL_NTRY;
                    end
                end
                osm_pkg::NT_REQ_ASSUME:
                begin
                    upd.accepted = 1'b1;
                end
                osm_pkg::NT_REQ_RELEASE:
                begin
                    if ((f & osm_pkg::FL_NASK) != '0)
                    begin
                        upd.accepted = 1'b1;
                        upd.flags    = (f & ~osm_pkg::FL_NASK) | osm_pkg::FL_ASK;
                    end
                end
                osm_pkg::NT_FORCED_ACQ:
                begin
                    upd.accepted = 1'b1;
                    upd.flags    = osm_pkg::SET_OWNED;
                end
                osm_pkg::NT_FORCED_DIV:
                begin
                    upd.accepted = 1'b1;
                    upd.flags    = osm_pkg::SET_UNOWNED;
                end
                default:
                begin
                    upd.accepted = 1'b0;
                end
            endcase
        end
    end

endmodule

@@ hdl/ownership_state_machine.sv @@
// ----------------------------------------------------------------------------
// ownership_state_machine
// Ownership flag state for one property, stepped by local operations and
// received notifications.
// ----------------------------------------------------------------------------
// Pipeline: 2 register stages (input register, then result register).
// Throughput: one transaction per cycle unless m_tready stalls the result;
//   the flag update is a single pass from the input register into the
//   state and result registers.
// Reset: flags return to Unowned|NotAbleToAcquire, no pending operation,
//   both register stages empty.
module ownership_state_machine
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [3:0] code, [7:4] zero fill
    input  logic [0:0]  s_tuser,   // [0] mode

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // [0] accepted, [14:1] flags,
                                   // [18:15] last_operation, [23:19] zero fill
);

    logic            in_valid_reg;
    logic            in_mode_reg;
    osm_pkg::code_t  in_code_reg;

    osm_pkg::flags_t flags_reg;
    osm_pkg::code_t  pend_reg;

    logic            out_valid_reg;
    osm_pkg::upd_t   out_reg;

    osm_pkg::upd_t   upd;
    logic            advance;
    logic            in_take;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign in_take  = s_tvalid && s_tready;

    osm_next u_next
    (
        .mode    (in_mode_reg),
        .code    (in_code_reg),
        .flags   (flags_reg),
        .pending (pend_reg),
        .upd     (upd)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            flags_reg     <= osm_pkg::FLAGS_RESET;
            pend_reg      <= osm_pkg::OP_NONE;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                flags_reg     <= upd.flags;
                pend_reg      <= upd.pending;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_mode_reg <= s_tuser[0];
            in_code_reg <= s_tdata[3:0];
        end
        if (advance)
        begin
            out_reg <= upd;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0, out_reg.pending, out_reg.flags, out_reg.accepted};

    a_flags_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        flags_reg != '0)
        else $error("flag set became empty");

    a_reject_holds: assert property (@(posedge clk) disable iff (!rst_n)
        advance && !upd.accepted |=> flags_reg == $past(flags_reg) &&
                                     pend_reg == $past(pend_reg))
        else $error("rejected transaction changed state");

    a_notif_keeps_pending: assert property (@(posedge clk) disable iff (!rst_n)
        advance && (in_mode_reg == osm_pkg::MODE_NOTIFICATION) |=>
        pend_reg == $past(pend_reg))
        else $error("notification changed pending operation");

    a_pending_legal: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg <= osm_pkg::OP_UNPUBLISH)
        else $error("pending operation out of range");

    a_result_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_reg.flags == flags_reg && out_reg.pending == pend_reg)
        else $error("result register disagrees with state");

endmodule

@@ sim/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Stream-level check of ownership_state_machine. A directed table walks every
// operation and notification, the rejected and undefined codes and both
// forced-reset overrides. A random phase follows: mostly codes whose guard
// holds in the current state, plus noise. Both handshake sides stall at
// random. Every result is compared with an in-bench prediction of its fields.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int              RANDOM_ITEMS = 1950;
    localparam int              CYCLE_LIMIT  = 400_000;
    localparam int              TAIL_CYCLES  = 12;
    localparam int              REPORT_MAX   = 10;
    localparam osm_pkg::code_t  OP_UNDEFINED = 4'd15;
    localparam osm_pkg::code_t  NT_UNDEFINED = 4'd9;
    localparam osm_pkg::upd_t   PREDICT      = '0;

    typedef struct packed {
        logic           mode;
        osm_pkg::code_t code;
        logic           typed;
        osm_pkg::upd_t  want;
    } dir_row_t;

    localparam int DIR_ROWS = 28;

    localparam dir_row_t DIRECTED [0:DIR_ROWS-1] = '{
        '{osm_pkg::MODE_OPERATION, osm_pkg::OP_NONE, 1'b1,
          '{1'b0, osm_pkg::FLAGS_RESET, osm_pkg::OP_NONE}},
        '{osm_pkg::MODE_NOTIFICATION, osm_pkg::NT_NONE, 1'b1,
          '{1'b0, osm_pkg::FLAGS_RESET, osm_pkg::OP_NONE}},
        '{osm_pkg::MODE_OPERATION, OP_UNDEFINED, 1'b1,
          '{1'b0, osm_pkg::FLAGS_RESET, osm_pkg::OP_NONE}},
        '{osm_pkg::MODE_NOTIFICATION, NT_UNDEFINED, 1'b1,
          '{1'b0, osm_pkg::FLAGS_RESET, osm_pkg::OP_NONE}},
        '{osm_pkg::MODE_OPERATION,    osm_pkg::OP_PUBLISH,        1'b0, PREDICT},
        '{osm_pkg::MODE_OPERATION,    osm_pkg::OP_ACQ_IF_AVAIL,   1'b0, PREDICT},
        '{osm_pkg::MODE_NOTIFICATION, osm_pkg::NT_UNAVAILABLE,    1'b0, PREDICT},
        '{osm_pkg::MODE_OPERATION,    osm_pkg::OP_ACQ,            1'b0, PREDICT},
        '{osm_pkg::MODE_OPERATION,    osm_pkg::OP_CANCEL_ACQ,     1'b0, PREDICT},
        '{osm_pkg::MODE_NOTIFICATION, osm_pkg::NT_CONFIRM_CANCEL, 1'b0, PREDICT},
        '{osm_pkg::MODE_OPERATION,    osm_pkg::OP_ACQ_IF_AVAIL,   1'b0, PREDICT},
        '{osm_pkg::MODE_NOTIFICATION, osm_pkg::NT_ACQUIRED,       1'b0, PREDICT},
        '{osm_pkg::MODE_NOTIFICATION, osm_pkg::NT_REQ_RELEASE,    1'b0, PREDICT},
        '{osm_pkg::MODE_OPERATION,    osm_pkg::OP_REL_FAIL,       1'b0, PREDICT},
        '{osm_pkg::MODE_NOTIFICATION, osm_pkg::NT_REQ_RELEASE,    1'b0, PREDICT},
        '{osm_pkg::MODE_OPERATION,    osm_pkg::OP_NEG_DIV,        1'b0, PREDICT},
        '{osm_pkg::MODE_OPERATION,    osm_pkg::OP_CANCEL_NEG,     1'b0, PREDICT},
        '{osm_pkg::MODE_OPERATION,    osm_pkg::OP_REL_SUCC,       1'b0, PREDICT},
        '{osm_pkg::MODE_OPERATION, osm_pkg::OP_FORCED_ACQ, 1'b1,
          '{1'b1, osm_pkg::SET_OWNED, osm_pkg::OP_FORCED_ACQ}},
        '{osm_pkg::MODE_OPERATION, osm_pkg::OP_UNCOND_DIV, 1'b1,
          '{1'b1, osm_pkg::SET_UNOWNED, osm_pkg::OP_NONE}},
        '{osm_pkg::MODE_NOTIFICATION, osm_pkg::NT_FORCED_ACQ,     1'b0, PREDICT},
        '{osm_pkg::MODE_OPERATION, osm_pkg::OP_FORCED_DIV, 1'b1,
          '{1'b1, osm_pkg::SET_UNOWNED, osm_pkg::OP_FORCED_DIV}},
        '{osm_pkg::MODE_OPERATION, osm_pkg::OP_ACQ, 1'b1,
          '{1'b1, osm_pkg::SET_OWNED, osm_pkg::OP_NONE}},
        '{osm_pkg::MODE_OPERATION,    osm_pkg::OP_NEG_DIV,        1'b0, PREDICT},
        '{osm_pkg::MODE_NOTIFICATION, osm_pkg::NT_DIVESTED,       1'b0, PREDICT},
        '{osm_pkg::MODE_NOTIFICATION, osm_pkg::NT_REQ_ASSUME,     1'b0, PREDICT},
        '{osm_pkg::MODE_NOTIFICATION, osm_pkg::NT_FORCED_DIV,     1'b0, PREDICT},
        '{osm_pkg::MODE_OPERATION, osm_pkg::OP_UNPUBLISH, 1'b1,
          '{1'b1, osm_pkg::FLAGS_RESET, osm_pkg::OP_UNPUBLISH}}
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic [0:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;

    osm_pkg::flags_t model_flags = osm_pkg::FLAGS_RESET;
    osm_pkg::code_t  model_pending = osm_pkg::OP_NONE;
    osm_pkg::upd_t   pending_updates [$];

    int cycle_count = 0;
    int mismatches = 0;
    int results_seen = 0;
    int accepted_seen = 0;
    int notifications_sent = 0;
    int sender_quiet = 0;
    int receiver_quiet = 0;

    ownership_state_machine dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #2 clk = ~clk;

    function automatic void next_ownership(input logic mode, input osm_pkg::code_t code,
                                           inout osm_pkg::flags_t f,
                                           inout osm_pkg::code_t pend,
                                           output logic ok);
        osm_pkg::flags_t n;
        osm_pkg::code_t  np;
        n  = f;
        np = pend;
        ok = 1'b1;
        if (mode == osm_pkg::MODE_OPERATION && pend == osm_pkg::OP_FORCED_ACQ &&
            (code == osm_pkg::OP_NEG_DIV || code == osm_pkg::OP_UNCOND_DIV ||
             code == osm_pkg::OP_FORCED_DIV))
        begin
            n  = osm_pkg::SET_UNOWNED;
            np = osm_pkg::OP_NONE;
        end
        else if (mode == osm_pkg::MODE_OPERATION && pend == osm_pkg::OP_FORCED_DIV &&
                 (code == osm_pkg::OP_ACQ || code == osm_pkg::OP_ACQ_IF_AVAIL ||
                  code == osm_pkg::OP_FORCED_ACQ))
        begin
            n  = osm_pkg::SET_OWNED;
            np = osm_pkg::OP_NONE;
        end
        else if (mode == osm_pkg::MODE_OPERATION)
        begin
            case (code)
                osm_pkg::OP_PUBLISH:
                begin
                    ok = |(f & osm_pkg::FL_NABLE);
                    n  = (f & ~osm_pkg::FL_NABLE) | osm_pkg::FL_ABLE | osm_pkg::FL_NACQ |
                         osm_pkg::FL_NTRY;
                    np = osm_pkg::OP_PUBLISH;
                end
                osm_pkg::OP_UNPUBLISH:
                begin
                    ok = ~|(f & osm_pkg::FL_NABLE);
                    n  = osm_pkg::FL_UNOWN | osm_pkg::FL_NABLE;
                    np = osm_pkg::OP_UNPUBLISH;
                end
                osm_pkg::OP_CANCEL_NEG:
                begin
                    ok = |(f & osm_pkg::FL_DIV);
                    n  = (f & ~osm_pkg::FL_DIV) | osm_pkg::FL_NDIV;
                    np = (pend == osm_pkg::OP_NEG_DIV) ? osm_pkg::OP_NONE
                                                       : osm_pkg::OP_CANCEL_NEG;
                end
                osm_pkg::OP_CANCEL_ACQ:
                begin
                    ok = |(f & osm_pkg::FL_ACQ);
                    n  = (f & ~osm_pkg::FL_ACQ) | osm_pkg::FL_TCANCEL;
                    np = osm_pkg::OP_CANCEL_ACQ;
                end
                osm_pkg::OP_NEG_DIV:
                begin
                    ok = |(f & osm_pkg::FL_NDIV);
                    n  = (f & ~osm_pkg::FL_NDIV) | osm_pkg::FL_DIV;
                    np = (pend == osm_pkg::OP_CANCEL_NEG) ? osm_pkg::OP_NONE
                                                          : osm_pkg::OP_NEG_DIV;
                end
                osm_pkg::OP_ACQ:
                begin
                    ok = |(f & osm_pkg::FL_NACQ);
                    n  = (f & ~(osm_pkg::FL_NACQ | osm_pkg::FL_WILL)) | osm_pkg::FL_ACQ |
                         osm_pkg::FL_PEND | osm_pkg::FL_NTRY;
                    np = osm_pkg::OP_ACQ;
                end
                osm_pkg::OP_ACQ_IF_AVAIL:
                begin
                    ok = |(f & osm_pkg::FL_NTRY) && ~|(f & osm_pkg::FL_PEND);
                    n  = (f & ~osm_pkg::FL_NTRY) | osm_pkg::FL_WILL;
                    np = osm_pkg::OP_ACQ_IF_AVAIL;
                end
                osm_pkg::OP_REL_FAIL:
                begin
                    ok = |(f & osm_pkg::FL_ASK);
                    n  = (f & ~osm_pkg::FL_ASK) | osm_pkg::FL_NASK;
                    np = osm_pkg::OP_REL_FAIL;
                end
                osm_pkg::OP_REL_SUCC:
                begin
                    ok = |(f & osm_pkg::FL_ASK);
                    n  = (f & ~(osm_pkg::FL_ASK | osm_pkg::FL_DIV | osm_pkg::FL_NDIV |
                                osm_pkg::FL_OWN)) | osm_pkg::SET_UNOWNED;
                    np = osm_pkg::OP_REL_SUCC;
                end
                osm_pkg::OP_UNCOND_DIV:
                begin
                    ok = |(f & osm_pkg::FL_OWN);
                    n  = (f & ~(osm_pkg::FL_ASK | osm_pkg::FL_DIV | osm_pkg::FL_NASK |
                                osm_pkg::FL_NDIV | osm_pkg::FL_OWN))
                         | osm_pkg::SET_UNOWNED;
                    np = osm_pkg::OP_UNCOND_DIV;
                end
                osm_pkg::OP_FORCED_ACQ:
                begin
                    ok = |(f & osm_pkg::FL_UNOWN);
                    n  = osm_pkg::SET_OWNED;
                    np = osm_pkg::OP_FORCED_ACQ;
                end
                osm_pkg::OP_FORCED_DIV:
                begin
                    ok = |(f & osm_pkg::FL_OWN);
                    n  = osm_pkg::SET_UNOWNED;
                    np = osm_pkg::OP_FORCED_DIV;
                end
                default: ok = 1'b0;
            endcase
        end
        else
        begin
            case (code)
                osm_pkg::NT_CONFIRM_CANCEL:
                begin
                    ok = |(f & osm_pkg::FL_TCANCEL);
                    n  = (f & ~(osm_pkg::FL_PEND | osm_pkg::FL_TCANCEL)) | osm_pkg::FL_NACQ;
                end
                osm_pkg::NT_ACQUIRED:
                begin
                    ok = |(f & (osm_pkg::FL_PEND | osm_pkg::FL_WILL));
                    n  = (f & ~(osm_pkg::FL_ABLE | osm_pkg::FL_ACQ | osm_pkg::FL_PEND |
                                osm_pkg::FL_NACQ | osm_pkg::FL_NTRY | osm_pkg::FL_TCANCEL |
                                osm_pkg::FL_UNOWN | osm_pkg::FL_WILL)) | osm_pkg::SET_OWNED;
                end
                osm_pkg::NT_DIVESTED:
                begin
                    ok = |(f & osm_pkg::FL_DIV);
                    n  = (f & ~(osm_pkg::FL_DIV | osm_pkg::FL_ASK | osm_pkg::FL_NASK |
                                osm_pkg::FL_OWN)) | osm_pkg::SET_UNOWNED;
                end
                osm_pkg::NT_UNAVAILABLE:
                begin
                    ok = |(f & osm_pkg::FL_WILL);
                    n  = (f & ~osm_pkg::FL_WILL) | osm_pkg::FL_NTRY;
                end
                osm_pkg::NT_REQ_ASSUME: ok = 1'b1;
                osm_pkg::NT_REQ_RELEASE:
                begin
                    ok = |(f & osm_pkg::FL_NASK);
                    n  = (f & ~osm_pkg::FL_NASK) | osm_pkg::FL_ASK;
                end
                osm_pkg::NT_FORCED_ACQ: n = osm_pkg::SET_OWNED;
                osm_pkg::NT_FORCED_DIV: n = osm_pkg::SET_UNOWNED;
                default:                ok = 1'b0;
            endcase
        end
        if (ok)
        begin
            f    = n;
            pend = np;
        end
    endfunction

    function automatic int draw_gap(inout int quiet_left);
        int r;
        r = $urandom_range(0, 99);
        if (quiet_left > 0)
        begin
            quiet_left--;
            return 0;
        end
        if (r < 3)
        begin
            quiet_left = $urandom_range(20, 80);
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_transaction(input logic mode, input osm_pkg::code_t code,
                                    input logic typed, input osm_pkg::upd_t want);
        osm_pkg::upd_t predicted;
        logic          ok;
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0000, code};
        s_tuser  <= mode;
        do
            @(posedge clk);
        while (!s_tready);
        next_ownership(mode, code, model_flags, model_pending, ok);
        predicted.accepted = ok;
        predicted.flags    = model_flags;
        predicted.pending  = model_pending;
        pending_updates.push_back(typed ? want : predicted);
        if (mode == osm_pkg::MODE_NOTIFICATION)
            notifications_sent++;
    endtask

    task automatic sender_idle();
        int n;
        n = draw_gap(sender_quiet);
        if (n > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_updates.size() != 0)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_updates.size());
            $display("FAIL ownership_state_machine");
            $finish;
        end
    end

    initial
    begin
        int n;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 16)) @(posedge clk);
            n = draw_gap(receiver_quiet);
            if (n > 0)
            begin
                m_tready <= 1'b0;
                repeat (n) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin : result_check
        osm_pkg::upd_t got;
        osm_pkg::upd_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.accepted = m_tdata[0];
            got.flags    = m_tdata[14:1];
            got.pending  = m_tdata[18:15];
            results_seen++;
            if (got.accepted)
                accepted_seen++;
            if (pending_updates.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("unexpected result: accepted=%b flags=%h last_op=%0d",
                             got.accepted, got.flags, got.pending);
            end
            else
            begin
                want = pending_updates.pop_front();
                if (got.accepted !== want.accepted || got.flags !== want.flags ||
                    got.pending !== want.pending)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display(
                            "result %0d: want acc=%b flags=%h op=%0d got acc=%b flags=%h op=%0d",
                            results_seen, want.accepted, want.flags, want.pending,
                            got.accepted, got.flags, got.pending);
                end
            end
        end
    end

    initial
    begin
        logic            mode;
        osm_pkg::code_t  code;
        osm_pkg::flags_t trial_flags;
        osm_pkg::code_t  trial_pending;
        logic            ok;
        int              tries;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIR_ROWS; i++)
        begin
            send_transaction(DIRECTED[i].mode, DIRECTED[i].code,
                             DIRECTED[i].typed, DIRECTED[i].want);
            sender_idle();
        end
        drain_results();

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if ($urandom_range(0, 99) < 80)
            begin
                tries = 0;
                do
                begin
                    mode = 1'($urandom_range(0, 1));
                    code = (mode == osm_pkg::MODE_NOTIFICATION) ? 4'($urandom_range(1, 8))
                                                                : 4'($urandom_range(1, 12));
                    trial_flags   = model_flags;
                    trial_pending = model_pending;
                    next_ownership(mode, code, trial_flags, trial_pending, ok);
                    tries++;
                end
                while (!ok && tries < 24);
            end
            else
            begin
                mode = 1'($urandom_range(0, 1));
                code = 4'($urandom_range(0, 15));
            end
            send_transaction(mode, code, 1'b0, PREDICT);
            if (i % 500 == 499)
                drain_results();
            else
                sender_idle();
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (pending_updates.size() != 0)
        begin
            mismatches++;
            $display("%0d expected results never arrived", pending_updates.size());
        end
        $display("checked %0d results (%0d accepted, %0d rejected), %0d notifications",
                 results_seen, accepted_seen, results_seen - accepted_seen,
                 notifications_sent);
        $display("mismatches: %0d over %0d cycles", mismatches, cycle_count);
        if (mismatches == 0)
            $display("PASS ownership_state_machine");
        else
            $display("FAIL ownership_state_machine");
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/osm_pkg.sv
hdl/osm_next.sv
hdl/ownership_state_machine.sv
sim/testbench.sv
